[rtl/bae_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the binary arithmetic encoder: action codes,
// controller commands, datapath status and the result word.
// ----------------------------------------------------------------------------
package bae_pkg;

  typedef enum logic [2:0] {
    ACT_CTX     = 3'd0,
    ACT_BYPASS  = 3'd1,
    ACT_TERM    = 3'd2,
    ACT_FLUSH   = 3'd3,
    ACT_RESTART = 3'd4
  } action_e;

  localparam logic [8:0]  RangeInit = 9'd510;
  localparam logic [4:0]  FreeInit  = 5'd23;
  localparam logic [7:0]  HeldInit  = 8'hff;
  localparam logic [4:0]  FreeMin   = 5'd12;
  localparam logic [7:0]  LpsMin    = 8'd6;
  localparam logic [5:0]  BinsMax   = 6'd32;

  typedef struct packed {
    logic load;
    logic restart;
    logic ctx;
    logic term;
    logic byp;
    logic emit1;
    logic emit2;
    logic fl1;
    logic fl2;
    logic fl3;
  } cmd_t;

  typedef struct packed {
    logic run_pending;
    logic byp_done;
    logic outst_gt1;
  } status_t;

  typedef struct packed {
    logic        push;
    logic [23:0] chunk_val;
    logic [4:0]  chunk_len;
    logic [31:0] rep_count;
    logic        pad;
  } result_t;

endpackage
`default_nettype wire

[rtl/bae_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bae_dpath
// Coding engine datapath: low, range, free bits, held byte and outstanding
// count, with the per-command arithmetic and the result word it produces.
// ----------------------------------------------------------------------------
module bae_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bae_pkg::cmd_t     cmd_i,
  input  logic              bin_value_i,
  input  logic              most_probable_i,
  input  logic [7:0]        lps_range_i,
  input  logic [31:0]       bypass_bits_i,
  input  logic [5:0]        bypass_count_i,
  output bae_pkg::status_t  status_o,
  output bae_pkg::result_t  result_o
);
  import bae_pkg::*;

  function automatic logic [3:0] renorm_shift(input logic [8:0] r);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 9; i++) begin
      if (r[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

  logic [31:0] low_q, low_d;
  logic [8:0]  range_q, range_d;
  logic [4:0]  free_q, free_d;
  logic [31:0] outst_q, outst_d;
  logic [7:0]  held_q, held_d;

  logic        bin_q, mps_q, carry_q, flag_q;
  logic [7:0]  lps_q;
  logic [31:0] bits_q;
  logic [5:0]  cnt_q;

  // context bin
  logic [8:0]  ctx_rsub, ctx_r, ctx_rn;
  logic [31:0] ctx_low;
  logic [3:0]  ctx_n;
  // terminate bin
  logic [8:0]  trm_rsub, trm_r;
  logic [31:0] trm_low;
  logic [3:0]  trm_n;
  // bypass group
  logic [3:0]  byp_s;
  logic [5:0]  byp_nc;
  logic [31:0] byp_shr, byp_low, byp_bits;
  logic [7:0]  byp_pat;
  logic [16:0] byp_prod;
  // lead byte
  logic [4:0]  em_sh, em_free;
  logic [31:0] em_lead, em_low;
  logic        em_due, em_is_ff, em_carry, out_nz, out_gt1;
  // flush
  logic [4:0]  fl_sh;
  logic        fl_c;
  logic [31:0] fl_low, fl_mask, fl_val;
  logic [3:0]  fl_nb;

  logic [5:0]  cnt_sat;

  always_comb begin
    ctx_rsub = range_q - {1'b0, lps_q};
    if (bin_q != mps_q) begin
      ctx_low = low_q + {23'd0, ctx_rsub};
      ctx_r   = {1'b0, lps_q};
    end else begin
      ctx_low = low_q;
      ctx_r   = ctx_rsub;
    end
    ctx_n  = renorm_shift(ctx_r);
    ctx_rn = ctx_r << ctx_n;

    trm_rsub = range_q - 9'd2;
    if (bin_q) begin
      trm_low = low_q + {23'd0, trm_rsub};
      trm_r   = 9'd256;
      trm_n   = 4'd7;
    end else begin
      trm_low = low_q;
      trm_n   = {3'b000, ~trm_rsub[8]};
      trm_r   = trm_rsub << trm_n;
    end

    byp_s    = (cnt_q > 6'd8) ? 4'd8 : cnt_q[3:0];
    byp_nc   = cnt_q - {2'b00, byp_s};
    byp_shr  = bits_q >> byp_nc;
    byp_pat  = byp_shr[7:0];
    byp_prod = {8'd0, range_q} * {9'd0, byp_pat};
    byp_low  = (low_q << byp_s) + {15'd0, byp_prod};
    byp_bits = bits_q & ~(32'hffff_ffff << byp_nc);

    em_due   = free_q < FreeMin;
    em_sh    = 5'd24 - free_q;
    em_lead  = low_q >> em_sh;
    em_free  = free_q + 5'd8;
    em_low   = low_q & (32'hffff_ffff >> em_free);
    em_is_ff = em_lead == 32'h0000_00ff;
    em_carry = em_lead[8];
    out_nz   = outst_q != 32'd0;
    out_gt1  = outst_q > 32'd1;

    fl_sh   = 5'd0 - free_q;
    fl_c    = (low_q >> fl_sh) != 32'd0;
    fl_low  = low_q - (32'd1 << fl_sh);
    fl_nb   = em_sh[3:0];
    fl_mask = ~(32'hffff_ffff << fl_nb);
    fl_val  = (((low_q >> 8) & fl_mask) << 1) | 32'd1;

    cnt_sat = (bypass_count_i > BinsMax) ? BinsMax : bypass_count_i;
  end

  always_comb begin
    result_o.push      = 1'b0;
    result_o.chunk_val = 24'd0;
    result_o.chunk_len = 5'd8;
    result_o.rep_count = 32'd1;
    result_o.pad       = 1'b0;
    if (cmd_i.emit1) begin
      result_o.push      = em_due && !em_is_ff && out_nz;
      result_o.chunk_val = {16'd0, held_q + {7'd0, em_carry}};
    end else if (cmd_i.emit2) begin
      result_o.push      = 1'b1;
      result_o.chunk_val = {16'd0, 8'hff + {7'd0, carry_q}};
      result_o.rep_count = outst_q - 32'd1;
    end else if (cmd_i.fl1) begin
      result_o.push      = fl_c || out_nz;
      result_o.chunk_val = {16'd0, held_q + {7'd0, fl_c}};
    end else if (cmd_i.fl2) begin
      result_o.push      = 1'b1;
      result_o.chunk_val = {16'd0, 8'hff + {7'd0, flag_q}};
      result_o.rep_count = outst_q - 32'd1;
    end else if (cmd_i.fl3) begin
      result_o.push      = 1'b1;
      result_o.chunk_val = fl_val[23:0];
      result_o.chunk_len = {1'b0, fl_nb} + 5'd1;
      result_o.pad       = 1'b1;
    end
  end

  assign status_o.run_pending = em_due && !em_is_ff && out_gt1;
  assign status_o.byp_done    = cnt_q == 6'd0;
  assign status_o.outst_gt1   = out_gt1;

  always_comb begin
    low_d   = low_q;
    range_d = range_q;
    free_d  = free_q;
    outst_d = outst_q;
    held_d  = held_q;
    if (cmd_i.restart) begin
      low_d   = 32'd0;
      range_d = RangeInit;
      free_d  = FreeInit;
      outst_d = 32'd0;
      held_d  = HeldInit;
    end else if (cmd_i.ctx) begin
      low_d   = ctx_low << ctx_n;
      range_d = ctx_rn;
      free_d  = free_q - {1'b0, ctx_n};
    end else if (cmd_i.term) begin
      low_d   = trm_low << trm_n;
      range_d = trm_r;
      free_d  = free_q - {1'b0, trm_n};
    end else if (cmd_i.byp) begin
      low_d  = byp_low;
      free_d = free_q - {1'b0, byp_s};
    end else if (cmd_i.emit1) begin
      if (em_due) begin
        free_d = em_free;
        low_d  = em_low;
        if (em_is_ff) begin
          outst_d = outst_q + 32'd1;
        end else begin
          held_d = em_lead[7:0];
          if (!out_gt1) outst_d = 32'd1;
        end
      end
    end else if (cmd_i.emit2 || cmd_i.fl2) begin
      outst_d = 32'd1;
    end else if (cmd_i.fl1) begin
      if (fl_c) low_d = fl_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= 32'd0;
      range_q <= RangeInit;
      free_q  <= FreeInit;
      outst_q <= 32'd0;
      held_q  <= HeldInit;
    end else begin
      low_q   <= low_d;
      range_q <= range_d;
      free_q  <= free_d;
      outst_q <= outst_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= bin_value_i;
      mps_q <= most_probable_i;
      lps_q <= (lps_range_i < LpsMin) ? LpsMin : lps_range_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q  <= cnt_sat;
      bits_q <= bypass_bits_i & ~(32'hffff_ffff << cnt_sat);
    end else if (cmd_i.byp) begin
      cnt_q  <= byp_nc;
      bits_q <= byp_bits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit1) carry_q <= em_carry;
    if (cmd_i.fl1) flag_q <= fl_c;
  end

`ifndef SYNTHESIS
  a_free_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit1 |=> free_q >= FreeMin)
    else $error("free bit count below limit after lead byte step");
  a_range_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_q[8])
    else $error("range not normalised");
`endif

endmodule
`default_nettype wire

[rtl/bae_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bae_ctrl
// Sequencer for the encoder: decodes the action of each input word and steps
// the datapath through arithmetic, lead byte, run and flush commands.
// ----------------------------------------------------------------------------
module bae_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  bae_pkg::status_t  status_i,
  input  logic              can_push_i,
  output bae_pkg::cmd_t     cmd_o,
  output logic              fin_o
);
  import bae_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_CTX  = 10'b00_0000_0010,
    ST_TERM = 10'b00_0000_0100,
    ST_BYP  = 10'b00_0000_1000,
    ST_EM1  = 10'b00_0001_0000,
    ST_EM2  = 10'b00_0010_0000,
    ST_FL1  = 10'b00_0100_0000,
    ST_FL2  = 10'b00_1000_0000,
    ST_FL3  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   byp_q, byp_d;
  logic   more_byp;

  assign in_ready_o = state_q == ST_IDLE;
  assign more_byp   = byp_q && !status_i.byp_done;

  always_comb begin
    state_d = state_q;
    byp_d   = byp_q;
    cmd_o   = '0;
    fin_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          byp_d      = 1'b0;
          unique case (action_e'(action_i))
            ACT_CTX:    state_d = ST_CTX;
            ACT_BYPASS: begin
              state_d = ST_BYP;
              byp_d   = 1'b1;
            end
            ACT_TERM:   state_d = ST_TERM;
            ACT_FLUSH:  state_d = ST_FL1;
            ACT_RESTART: begin
              cmd_o.restart = 1'b1;
              state_d       = ST_FIN;
            end
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_CTX: begin
        cmd_o.ctx = 1'b1;
        state_d   = ST_EM1;
      end
      ST_TERM: begin
        cmd_o.term = 1'b1;
        state_d    = ST_EM1;
      end
      ST_BYP: begin
        cmd_o.byp = 1'b1;
        state_d   = ST_EM1;
      end
      ST_EM1: begin
        if (can_push_i) begin
          cmd_o.emit1 = 1'b1;
          if (status_i.run_pending) state_d = ST_EM2;
          else if (more_byp)        state_d = ST_BYP;
          else                      state_d = ST_FIN;
        end
      end
      ST_EM2: begin
        if (can_push_i) begin
          cmd_o.emit2 = 1'b1;
          state_d     = more_byp ? ST_BYP : ST_FIN;
        end
      end
      ST_FL1: begin
        if (can_push_i) begin
          cmd_o.fl1 = 1'b1;
          state_d   = status_i.outst_gt1 ? ST_FL2 : ST_FL3;
        end
      end
      ST_FL2: begin
        if (can_push_i) begin
          cmd_o.fl2 = 1'b1;
          state_d   = ST_FL3;
        end
      end
      ST_FL3: begin
        if (can_push_i) begin
          cmd_o.fl3 = 1'b1;
          state_d   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_push_i) begin
          fin_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      byp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      byp_q   <= byp_d;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again straight after a word");
  a_run_after_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM2) |-> $past(state_q == ST_EM1 || state_q == ST_EM2))
    else $error("run step without lead byte step");
`endif

endmodule
`default_nettype wire

[rtl/bae_outbuf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bae_outbuf
// Result staging: holds the latest result until the next one or the end of
// the input word decides its last flag, then moves it to the output register.
// ----------------------------------------------------------------------------
module bae_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bae_pkg::result_t  result_i,
  input  logic              fin_i,
  output logic              can_push_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [23:0]       chunk_value_o,
  output logic [4:0]        chunk_bits_o,
  output logic [31:0]       repeat_count_o,
  output logic              pad_after_o,
  output logic              last_o
);
  import bae_pkg::*;

  logic        s_valid_q, o_valid_q;
  result_t     s_q;
  logic [23:0] o_val_q;
  logic [4:0]  o_len_q;
  logic [31:0] o_rep_q;
  logic        o_pad_q, o_last_q;
  logic        o_load;

  assign can_push_o = !o_valid_q || out_ready_i;
  assign o_load     = (result_i.push || fin_i) && s_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (result_i.push)  s_valid_q <= 1'b1;
      else if (fin_i)     s_valid_q <= 1'b0;
      if (o_load)           o_valid_q <= 1'b1;
      else if (out_ready_i) o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.push) s_q <= result_i;
    if (o_load) begin
      o_val_q  <= s_q.chunk_val;
      o_len_q  <= s_q.chunk_len;
      o_rep_q  <= s_q.rep_count;
      o_pad_q  <= s_q.pad;
      o_last_q <= fin_i;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign chunk_value_o  = o_val_q;
  assign chunk_bits_o   = o_len_q;
  assign repeat_count_o = o_rep_q;
  assign pad_after_o    = o_pad_q;
  assign last_o         = o_last_q;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((result_i.push || fin_i) && o_valid_q) |-> out_ready_i)
    else $error("output register overwritten while held");
  a_fin_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_i |=> !s_valid_q)
    else $error("staged result left behind at end of word");
`endif

endmodule
`default_nettype wire

[rtl/binary_arithmetic_encoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_top
// Binary arithmetic coding engine: context, bypass and terminate bins, flush
// and restart, giving byte, run and final chunk write requests.
// ----------------------------------------------------------------------------
// Context and terminate words run load, arithmetic, lead byte, run (only when
// outstanding bytes are written) and final steps, one datapath command per
// cycle unless the output stalls. Bypass words repeat bypass and lead byte
// steps per group of up to 8 bins (4 groups at most). Flush has three flush
// steps, the second only for a run. Results wait for the next one or the end
// of the word, then are registered out; stalls hold the sequencer. Async reset.
module binary_arithmetic_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic        bin_value_i,
  input  logic        most_probable_i,
  input  logic [7:0]  lps_range_i,
  input  logic [31:0] bypass_bits_i,
  input  logic [5:0]  bypass_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] chunk_value_o,
  output logic [4:0]  chunk_bits_o,
  output logic [31:0] repeat_count_o,
  output logic        pad_after_o,
  output logic        last_o
);
  import bae_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;
  logic    fin;
  logic    can_push;

  bae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .status_i   (status),
    .can_push_i (can_push),
    .cmd_o      (cmd),
    .fin_o      (fin)
  );

  bae_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .bin_value_i     (bin_value_i),
    .most_probable_i (most_probable_i),
    .lps_range_i     (lps_range_i),
    .bypass_bits_i   (bypass_bits_i),
    .bypass_count_i  (bypass_count_i),
    .status_o        (status),
    .result_o        (result)
  );

  bae_outbuf u_outbuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_i       (result),
    .fin_i          (fin),
    .can_push_o     (can_push),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chunk_value_o  (chunk_value_o),
    .chunk_bits_o   (chunk_bits_o),
    .repeat_count_o (repeat_count_o),
    .pad_after_o    (pad_after_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
